// ===== rtl/ppe_pkg.sv =====
// Shared types, constants and helper functions for the piecewise polynomial evaluator.
`default_nettype none

package ppe_pkg;

  // Default configuration of the evaluator.
  localparam int DEF_SECTIONS = 3;
  localparam int DEF_TERMS    = 9;

  // Table slots that hold the base terms of section 0.
  localparam int BASE_SLOTS = 2;

  // Number of boundary registers on the configuration port.
  localparam int NUM_BOUNDS = 3;
  localparam int CFG_IW     = 2;

  // Reset values of the boundary registers, Q8.24.
  localparam logic [31:0] BND_RST_FIRST  = 32'd33554432;
  localparam logic [31:0] BND_RST_SECOND = 32'd92274688;
  localparam logic [31:0] BND_RST_THIRD  = 32'd125829120;

  // Command codes of an input item.
  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Saturation bounds of a Q16.32 result, sign extended to 64 bits.
  localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOUND,
    ST_FETCH,
    ST_INIT,
    ST_LO,
    ST_HI,
    ST_SUM,
    ST_ADD,
    ST_END,
    ST_DONE
  } ppe_state_t;

  typedef enum logic {
    PASS_VAL,
    PASS_DER
  } ppe_pass_t;

  // One-hot step strobes from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic init;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic add;
  } ppe_mac_op_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[47:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] bnd_reset(input int idx);
    logic [31:0] r;
    case (idx)
      0:       r = BND_RST_FIRST;
      1:       r = BND_RST_SECOND;
      2:       r = BND_RST_THIRD;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppe_coef_mem.sv =====
// Coefficient table: one write port and one registered read port.
`default_nettype none

module ppe_coef_mem
  import ppe_pkg::*;
#(
  parameter int DEPTH = 2 + (DEF_TERMS - 2) * DEF_SECTIONS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic signed [47:0]   wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic signed [47:0]        rd_data
);

  logic signed [47:0] mem [DEPTH];
  logic signed [47:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/ppe_mac.sv =====
// Shared Horner step unit: split multiply, rounding, saturation and coefficient add.
`default_nettype none

module ppe_mac
  import ppe_pkg::*;
#(
  parameter int TERMS = DEF_TERMS,
  localparam int KW   = $clog2(TERMS)
) (
  input  wire logic               clk,
  input  wire ppe_mac_op_t        op,
  input  wire logic [KW-1:0]      k,
  input  wire logic signed [47:0] coef_in,
  input  wire logic signed [32:0] dx,
  output logic signed [47:0]      acc
);

  localparam logic signed [58:0] RND_HALF = 59'sd8388608;

  logic signed [47:0] acc_r;
  logic signed [47:0] coef_r;
  logic signed [58:0] plo_r;
  logic signed [56:0] phi_r;
  logic signed [47:0] rnd_r;

  logic signed [48+KW:0] kc_raw;
  logic signed [47:0]    kc_sat;
  logic signed [57:0]    plo_raw;
  logic signed [56:0]    phi_raw;
  logic                  neg;

  // Scaled coefficient: k times the table entry, saturated.
  assign kc_raw = $signed({1'b0, k}) * coef_in;
  assign kc_sat = sat48(64'(kc_raw));

  // The 48 by 33 product is formed from a low and a high 24-bit half of the accumulator.
  assign plo_raw = $signed({1'b0, acc_r[23:0]}) * dx;
  assign phi_raw = $signed(acc_r[47:24]) * dx;

  // Sign of the product; for a zero product the rounding still yields zero.
  assign neg = acc_r[47] ^ dx[32];

  always_ff @(posedge clk) begin
    if (op.init) begin
      acc_r <= kc_sat;
    end
    if (op.mul_lo) begin
      plo_r <= 59'(plo_raw);
    end
    if (op.mul_hi) begin
      phi_r  <= phi_raw;
      coef_r <= kc_sat;
      // Half away from zero: add one half, less one unit when the product is negative.
      plo_r  <= plo_r + RND_HALF - $signed({58'd0, neg});
    end
    if (op.sum) begin
      rnd_r <= sat48(64'(phi_r + (plo_r >>> 24)));
    end
    if (op.add) begin
      acc_r <= sat48(64'(rnd_r) + 64'(coef_r));
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== rtl/ppe_ctrl.sv =====
// Sequencer: section walk, Horner passes, table reads and the result register.
`default_nettype none

module ppe_ctrl
  import ppe_pkg::*;
#(
  parameter int SECTIONS = DEF_SECTIONS,
  parameter int TERMS    = DEF_TERMS,
  localparam int DEPTH   = 2 + (TERMS - 2) * SECTIONS,
  localparam int AW      = $clog2(DEPTH),
  localparam int KW      = $clog2(TERMS),
  localparam int SW      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_command,
  input  wire logic [4:0]                in_coeff_index,
  input  wire logic signed [47:0]        in_coeff_value,
  input  wire logic signed [31:0]        in_x_value,
  input  wire logic [SECTIONS-1:0][31:0] bnd,
  output logic                           mem_wr_en,
  output logic [AW-1:0]                  mem_wr_addr,
  output logic signed [47:0]             mem_wr_data,
  output logic                           mem_rd_en,
  output logic [AW-1:0]                  mem_rd_addr,
  input  wire logic signed [47:0]        mem_rd_data,
  output ppe_mac_op_t                    mac_op,
  output logic [KW-1:0]                  mac_k,
  output logic signed [47:0]             mac_coef,
  output logic signed [32:0]             mac_dx,
  input  wire logic signed [47:0]        mac_acc,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [47:0]             out_poly_value,
  output logic signed [47:0]             out_poly_slope
);

  localparam logic [KW-1:0] J_TOP = KW'(TERMS - 1);
  localparam logic [SW-1:0] S_TOP = SW'(SECTIONS - 1);

  ppe_state_t state_r, state_nxt;

  logic [SW-1:0]      sec_r;
  logic [AW-1:0]      base_r;
  logic [KW-1:0]      j_r;
  ppe_pass_t          pass_r;
  logic               last_r;
  logic signed [31:0] x_r;
  logic signed [32:0] dx_r;
  logic signed [47:0] val_r;
  logic signed [47:0] der_r;
  logic signed [47:0] vnew_r;
  logic               out_valid_r;
  logic signed [47:0] out_value_r;
  logic signed [47:0] out_slope_r;

  logic               in_xfer;
  logic               out_free;
  logic [SW-1:0]      sec_next;
  logic               last_now;
  logic signed [31:0] end_now;
  logic signed [32:0] dx_now;
  logic [KW-1:0]      j_lo;
  logic               at_lo;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Section boundary: the walk stops at the last section or once x lies below the next start.
  assign sec_next = (sec_r == S_TOP) ? '0 : SW'(sec_r + 1'b1);
  assign last_now = (sec_r == S_TOP) || (x_r < $signed(bnd[sec_next]));
  assign end_now  = last_now ? x_r : $signed(bnd[sec_next]);
  assign dx_now   = 33'(end_now) - 33'($signed(bnd[sec_r]));

  assign j_lo  = (pass_r == PASS_DER) ? KW'(1) : '0;
  assign at_lo = (j_r == j_lo);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_command == CMD_EVAL) begin
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_LO;
      ST_LO:    state_nxt = ST_HI;
      ST_HI:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_ADD;
      ST_ADD:   state_nxt = at_lo ? ST_END : ST_LO;
      ST_END: begin
        if (pass_r == PASS_VAL) begin
          state_nxt = ST_FETCH;
        end else if (last_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_BOUND;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    mem_rd_en = 1'b0;
    mac_op    = '0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_FETCH: mem_rd_en = 1'b1;
      ST_INIT:  mac_op.init = 1'b1;
      ST_LO: begin
        mem_rd_en     = 1'b1;
        mac_op.mul_lo = 1'b1;
      end
      ST_HI:    mac_op.mul_hi = 1'b1;
      ST_SUM:   mac_op.sum = 1'b1;
      ST_ADD:   mac_op.add = 1'b1;
      ST_BOUND, ST_END, ST_DONE: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Table writes come only while idle, so they never meet a read of the same pass.
  assign mem_wr_en   = in_xfer && (in_command == CMD_WRITE) && (32'(in_coeff_index) < DEPTH);
  assign mem_wr_addr = AW'(in_coeff_index);
  assign mem_wr_data = in_coeff_value;

  assign mem_rd_addr = (j_r < KW'(BASE_SLOTS)) ? AW'(j_r) : AW'(base_r + AW'(j_r));

  // Later sections take their two lowest terms from the previous section's results.
  always_comb begin
    if (sec_r != '0 && j_r < KW'(BASE_SLOTS)) begin
      mac_coef = (j_r == '0) ? val_r : der_r;
    end else begin
      mac_coef = mem_rd_data;
    end
  end

  assign mac_k  = (pass_r == PASS_DER) ? j_r : KW'(1);
  assign mac_dx = dx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sec_r   <= '0;
      base_r  <= '0;
      j_r     <= J_TOP;
      pass_r  <= PASS_VAL;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer && in_command == CMD_EVAL) begin
            sec_r  <= '0;
            base_r <= '0;
            j_r    <= J_TOP;
            pass_r <= PASS_VAL;
          end
        end
        ST_BOUND: last_r <= last_now;
        ST_INIT:  j_r <= j_r - 1'b1;
        ST_ADD: begin
          if (!at_lo) begin
            j_r <= j_r - 1'b1;
          end
        end
        ST_END: begin
          j_r <= J_TOP;
          if (pass_r == PASS_VAL) begin
            pass_r <= PASS_DER;
          end else begin
            pass_r <= PASS_VAL;
            if (!last_r) begin
              sec_r  <= sec_next;
              base_r <= AW'(base_r + AW'(TERMS - 2));
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_xfer) begin
      x_r <= in_x_value;
    end
    if (state_r == ST_BOUND) begin
      dx_r <= dx_now;
    end
    if (state_r == ST_END) begin
      if (pass_r == PASS_VAL) begin
        vnew_r <= mac_acc;
      end else begin
        val_r <= vnew_r;
        der_r <= mac_acc;
      end
    end
  end

  // Result register: a finished result can wait here while the next item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_value_r <= val_r;
      out_slope_r <= der_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_poly_value = out_value_r;
  assign out_poly_slope = out_slope_r;

endmodule

`default_nettype wire

// ===== rtl/piecewise_poly_c1_eval.sv =====
// Items are taken one at a time: an evaluate item holds in_stall high until its result
// is in the result register, while a write item is taken in the idle state.
// Each Horner step runs the low multiply, high multiply, sum and add steps on the shared
// multiply-accumulate unit, and the single read port of the coefficient table feeds it.
// Reset (synchronous, rst_n low) clears the sequencer and the result valid and loads the
// boundary registers; the coefficient table is not cleared and is undefined until written.
`default_nettype none

module piecewise_poly_c1_eval
  import ppe_pkg::*;
#(
  parameter int SECTIONS = DEF_SECTIONS,
  parameter int TERMS    = DEF_TERMS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_IW-1:0]   cfg_index,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_command,
  input  wire logic [4:0]          in_coeff_index,
  input  wire logic signed [47:0]  in_coeff_value,
  input  wire logic signed [31:0]  in_x_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [47:0]       out_poly_value,
  output logic signed [47:0]       out_poly_slope
);

  // The table holds the two base terms of section 0 and TERMS-2 higher terms per section.
  localparam int DEPTH = 2 + (TERMS - 2) * SECTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(TERMS);

  // Section start points in Q8.24. Only the first three are reachable from the
  // configuration port; any further ones stay at zero.
  logic [SECTIONS-1:0][31:0] bnd_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < SECTIONS; i++) begin
      if (!rst_n) begin
        bnd_r[i] <= bnd_reset(i);
      end else if (cfg_wr_en && i < NUM_BOUNDS && cfg_index == CFG_IW'(i)) begin
        bnd_r[i] <= cfg_wdata;
      end
    end
  end

  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic signed [47:0]  mem_wr_data;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic signed [47:0]  mem_rd_data;
  ppe_mac_op_t         mac_op;
  logic [KW-1:0]       mac_k;
  logic signed [47:0]  mac_coef;
  logic signed [32:0]  mac_dx;
  logic signed [47:0]  mac_acc;

  // The sequencer walks the sections. For each section it computes the offset dx,
  // runs a Horner pass for the value and one for the derivative on the shared unit,
  // and then hands the value and slope on as the next section's lowest two terms.
  ppe_ctrl #(
    .SECTIONS (SECTIONS),
    .TERMS    (TERMS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_coeff_index (in_coeff_index),
    .in_coeff_value (in_coeff_value),
    .in_x_value     (in_x_value),
    .bnd            (bnd_r),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .mac_op         (mac_op),
    .mac_k          (mac_k),
    .mac_coef       (mac_coef),
    .mac_dx         (mac_dx),
    .mac_acc        (mac_acc),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_poly_value (out_poly_value),
    .out_poly_slope (out_poly_slope)
  );

  // Coefficient storage. Writes arrive only while the sequencer is idle, so a
  // read and a write of the same entry never overlap.
  ppe_coef_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // One Horner step: the running Q16.32 value times dx is rounded half away from
  // zero back to Q16.32, saturated, added to the (scaled) coefficient and saturated.
  ppe_mac #(
    .TERMS (TERMS)
  ) u_mac (
    .clk     (clk),
    .op      (mac_op),
    .k       (mac_k),
    .coef_in (mac_coef),
    .dx      (mac_dx),
    .acc     (mac_acc)
  );

endmodule

`default_nettype wire
